FILE: design/stp_pkg.sv
// Shared constants for the stepper speed-ramp step generator.
`default_nettype none
package stp_pkg;

  localparam int SPEED_W   = 16;
  localparam int PERIOD_W  = 24;
  localparam int POS_W     = 32;
  localparam int ACCEL_W   = 15;
  localparam int SCALE_W   = 8;
  localparam int DIR_W     = 2;
  localparam int IDX_W     = 2;
  localparam int CFG_W     = 24;
  localparam int DIV_STEPS = PERIOD_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int OUT_W     = 80;

  localparam logic MODE_SPEED = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
  localparam logic [DIR_W-1:0] DIR_FWD  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_REV  = 2'd2;

  localparam logic [IDX_W-1:0] REG_ACCEL_LIMIT = 2'd0;
  localparam logic [IDX_W-1:0] REG_ZERO_PERIOD = 2'd1;
  localparam logic [IDX_W-1:0] REG_SPEED_SCALE = 2'd2;

  localparam logic [ACCEL_W-1:0]  ACCEL_LIMIT_RST = 15'd8;
  localparam logic [PERIOD_W-1:0] ZERO_PERIOD_RST = 24'd65535;
  localparam logic [SCALE_W-1:0]  SPEED_SCALE_RST = 8'd50;

endpackage
`default_nettype wire

FILE: design/stp_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
`default_nettype none
module stp_div
  import stp_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [PERIOD_W-1:0] dividend,
  input  wire logic [SPEED_W-1:0]  divisor,
  output logic                     busy,
  output logic [PERIOD_W-1:0]      quotient
);

  logic [PERIOD_W-1:0]  dq_r, dq_nxt;
  logic [SPEED_W-1:0]   rem_r, rem_nxt;
  logic [SPEED_W-1:0]   dvs_r, dvs_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic [SPEED_W:0]     trial;
  logic [SPEED_W+1:0]   sub;
  logic                 ge;

  assign trial = {rem_r, dq_r[PERIOD_W-1]};
  assign sub   = {1'b0, trial} - {2'b00, dvs_r};
  assign ge    = ~sub[SPEED_W+1];

  always_comb begin
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      dq_nxt   = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? sub[SPEED_W-1:0] : trial[SPEED_W-1:0];
      dq_nxt  = {dq_r[PERIOD_W-2:0], ge};
      cnt_nxt = cnt_r + DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = busy_r;
  assign quotient = dq_r;

endmodule
`default_nettype wire

FILE: design/stepper_speed_ramp_step_gen.sv
// Top level of one stepper channel: speed ramp, step period and position count.
// Usage:
//   in_tvalid/in_tready/in_tuser/in_tdata carry one word per item. in_tuser is
//   the mode: 0 speed command (in_tdata holds the signed target speed),
//   1 timer-alarm tick (in_tdata ignored).
//   out_tvalid/out_tready/out_tdata return exactly one result word per item.
//   cfg_we/cfg_index/cfg_wdata write the acceleration limit (0), zero_speed_period
//   (1) and speed_scale (2); write only while the block is idle.
// Timing:
//   A speed command with nonzero scaled speed passes through RAMP, SCALE, DIVGO,
//   DIVWT, where the bit-serial divider forms one quotient bit per cycle, CLAMP
//   and DONE, which raises out_tvalid. A command with zero scaled speed skips
//   DIVWT; a tick goes straight to DONE. One item is in work at a time; in_tready
//   rises together with out_tvalid.
// Reset:
//   rst_n (synchronous, active low) stops motion, clears speed and position,
//   loads the register defaults and sets the step period to 65535.
// Stall:
//   The result waits in the output register; the block accepts the next item
//   meanwhile and holds its own result until the output register frees up.
`default_nettype none
module stepper_speed_ramp_step_gen
  import stp_pkg::*;
#(
  parameter int TIMER_CLOCK_HZ = 2000000
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic             in_tuser,   // mode
  input  wire logic [15:0]      in_tdata,   // target_speed
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  // held_speed[15:0], step_period[39:16], motion_dir[41:40], dir_pin[42],
  // step_pulse[43], step_position[75:44], zero pad[79:76]
  output logic [OUT_W-1:0]      out_tdata,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  localparam logic [PERIOD_W-1:0] TIMER_HZ = PERIOD_W'(TIMER_CLOCK_HZ);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RAMP  = 3'd1;
  localparam logic [2:0] S_SCALE = 3'd2;
  localparam logic [2:0] S_DIVGO = 3'd3;
  localparam logic [2:0] S_DIVWT = 3'd4;
  localparam logic [2:0] S_CLAMP = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]                state_r, state_nxt;
  logic [ACCEL_W-1:0]        accel_r;
  logic [PERIOD_W-1:0]       zsp_r;
  logic [SCALE_W-1:0]        scale_r;
  logic signed [SPEED_W-1:0] target_r, target_nxt;
  logic signed [SPEED_W-1:0] ramp_r, ramp_nxt;
  logic signed [SPEED_W-1:0] scaled_r, scaled_nxt;
  logic [DIR_W-1:0]          dir_r, dir_nxt;
  logic                      pin_r, pin_nxt;
  logic [PERIOD_W-1:0]       period_r, period_nxt;
  logic [POS_W-1:0]          pos_r, pos_nxt;
  logic                      pulse_r, pulse_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]          out_data_r, out_data_nxt;

  logic                      in_acc;
  logic signed [SPEED_W:0]   diff, lim, ramp_up, ramp_dn;
  logic signed [24:0]        prod;
  logic [SPEED_W-1:0]        mag;
  logic [PERIOD_W-1:0]       quotient, base_q;
  logic                      div_start;
  logic                      div_busy;
  logic                      out_free;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign diff    = {ramp_r[SPEED_W-1], ramp_r} - {target_r[SPEED_W-1], target_r};
  assign lim     = {2'b00, accel_r};
  assign ramp_dn = {ramp_r[SPEED_W-1], ramp_r} - lim;
  assign ramp_up = {ramp_r[SPEED_W-1], ramp_r} + lim;

  assign prod   = 25'(ramp_r) * 25'($signed({1'b0, scale_r}));
  assign mag    = scaled_r[SPEED_W-1] ? (SPEED_W'(0) - scaled_r) : scaled_r;
  assign base_q = (scaled_r == '0) ? zsp_r : quotient;

  stp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (TIMER_HZ),
    .divisor  (mag),
    .busy     (div_busy),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_r <= ACCEL_LIMIT_RST;
      zsp_r   <= ZERO_PERIOD_RST;
      scale_r <= SPEED_SCALE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ACCEL_LIMIT: accel_r <= cfg_wdata[ACCEL_W-1:0];
        REG_ZERO_PERIOD: zsp_r   <= cfg_wdata[PERIOD_W-1:0];
        REG_SPEED_SCALE: scale_r <= cfg_wdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    target_nxt    = target_r;
    ramp_nxt      = ramp_r;
    scaled_nxt    = scaled_r;
    dir_nxt       = dir_r;
    pin_nxt       = pin_r;
    period_nxt    = period_r;
    pos_nxt       = pos_r;
    pulse_nxt     = pulse_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    div_start     = 1'b0;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          target_nxt = $signed(in_tdata);
          pulse_nxt  = 1'b0;
          if (in_tuser == MODE_TICK) begin
            state_nxt = S_DONE;
            if (dir_r != DIR_STOP) begin
              pulse_nxt = 1'b1;
              pos_nxt   = (dir_r == DIR_FWD) ? pos_r - POS_W'(1) : pos_r + POS_W'(1);
            end
          end else begin
            state_nxt = S_RAMP;
          end
        end
      end
      S_RAMP: begin
        if (diff > lim) begin
          ramp_nxt = ramp_dn[SPEED_W-1:0];
        end else if (diff < -lim) begin
          ramp_nxt = ramp_up[SPEED_W-1:0];
        end else begin
          ramp_nxt = target_r;
        end
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        if (prod > 25'sd32767) begin
          scaled_nxt = 16'sh7FFF;
        end else if (prod < -25'sd32768) begin
          scaled_nxt = 16'sh8000;
        end else begin
          scaled_nxt = prod[SPEED_W-1:0];
        end
        state_nxt = S_DIVGO;
      end
      S_DIVGO: begin
        if (scaled_r == '0) begin
          dir_nxt   = DIR_STOP;
          state_nxt = S_CLAMP;
        end else begin
          dir_nxt   = scaled_r[SPEED_W-1] ? DIR_REV : DIR_FWD;
          pin_nxt   = scaled_r[SPEED_W-1];
          div_start = 1'b1;
          state_nxt = S_DIVWT;
        end
      end
      S_DIVWT: begin
        if (!div_busy) begin
          state_nxt = S_CLAMP;
        end
      end
      S_CLAMP: begin
        if (base_q > zsp_r) begin
          period_nxt = zsp_r;
        end else begin
          period_nxt = base_q;
        end
        if (period_nxt == '0) begin
          period_nxt = PERIOD_W'(1);
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {4'b0000, pos_r, pulse_r, pin_r, dir_r, period_r, ramp_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ramp_r      <= '0;
      dir_r       <= DIR_STOP;
      pin_r       <= 1'b0;
      period_r    <= ZERO_PERIOD_RST;
      pos_r       <= '0;
      pulse_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ramp_r      <= ramp_nxt;
      dir_r       <= dir_nxt;
      pin_r       <= pin_nxt;
      period_r    <= period_nxt;
      pos_r       <= pos_nxt;
      pulse_r     <= pulse_nxt;
      out_valid_r <= out_valid_nxt;
    end
    target_r   <= target_nxt;
    scaled_r   <= scaled_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_period_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    period_r != '0)
    else $error("step period reached zero");

  a_div_only_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> (state_r == S_DIVWT))
    else $error("divider busy outside its wait state");

  a_stopped_tick_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_tuser == MODE_TICK) && (dir_r == DIR_STOP)) |=>
      ($stable(pos_r) && !pulse_r))
    else $error("tick while stopped moved the position");

endmodule
`default_nettype wire
